[src/linear_regression_gd_trainer_unit_macros.svh]
// ----------------------------------------------------------------------------
// linear_regression_gd_trainer_unit_macros
// assertion helpers for the trainer
// ----------------------------------------------------------------------------
`ifndef LINEAR_REGRESSION_GD_TRAINER_UNIT_MACROS_SVH
`define LINEAR_REGRESSION_GD_TRAINER_UNIT_MACROS_SVH

`define LRGD_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed");

`define LRGD_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

[src/lrgd_pkg.sv]
// ----------------------------------------------------------------------------
// lrgd_pkg
// types and constants of the gradient descent trainer
// ----------------------------------------------------------------------------
`default_nettype none
package lrgd_pkg;

  typedef enum logic [1:0] {
    CmdLoadFeature = 2'd0,
    CmdLoadTarget  = 2'd1,
    CmdStart       = 2'd2,
    CmdUnused      = 2'd3
  } cmd_e;

  localparam logic [1:0] RegLearningRate = 2'd0;
  localparam logic [1:0] RegEpochCount   = 2'd1;
  localparam logic [1:0] RegSampleCount  = 2'd2;

  localparam logic [15:0] ResetLr      = 16'd6554;
  localparam logic [9:0]  ResetEpochs  = 10'd100;
  localparam logic [9:0]  ResetSamples = 10'd506;

  typedef enum logic [3:0] {
    StIdle,
    StClear,
    StPredRd,
    StPredMul,
    StPredAcc,
    StErr,
    StGradMul,
    StGradAcc,
    StDivStart,
    StDivRun,
    StUpdMul,
    StUpdWr,
    StEmit
  } state_e;

  function automatic logic signed [63:0] drop16(input logic signed [63:0] v);
    logic [63:0] m;
    logic [63:0] s;
    begin
      m = v[63] ? (64'd0 - 64'(v)) : 64'(v);
      s = m >> 16;
      drop16 = v[63] ? -$signed(s) : $signed(s);
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    begin
      if (v > 66'sd2147483647) sat32 = 32'sh7fffffff;
      else if (v < -66'sd2147483648) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
    end
  endfunction

endpackage
`default_nettype wire

[src/linear_regression_gd_trainer_unit.sv]
// ----------------------------------------------------------------------------
// linear_regression_gd_trainer_unit
// loads samples into memory and trains a bias-free linear model
// ----------------------------------------------------------------------------
// channel | direction | signals
// in      | input     | in_valid_i/in_ready_o, command, sample_index, feature_index, value
// out     | output    | out_valid_o/out_ready_i, weight_index, weight_value, last_weight
// cfg     | input     | cfg_we_i, cfg_index_i, cfg_data_i
// loads are accepted back to back while idle.
// training time is set by the single feature memory read port
// and the bit-serial divider.
// weights leave one per transfer; the input stalls until the last is taken.
// reset clears control state and registers except the memory read registers; memories are undefined until loaded.
`default_nettype none
`include "linear_regression_gd_trainer_unit_macros.svh"
module linear_regression_gd_trainer_unit #(
  parameter int MAX_SAMPLES = 512,
  parameter int FEATURES    = 13
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [8:0]  sample_index_i,
  input  wire logic [3:0]  feature_index_i,
  input  wire logic signed [31:0] value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       weight_index_o,
  output logic signed [31:0] weight_value_o,
  output logic             last_weight_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  localparam int SW = $clog2(MAX_SAMPLES);
  localparam int FW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int AW = $clog2(MAX_SAMPLES * FEATURES);
  localparam int NW = $clog2(MAX_SAMPLES + 1);
  localparam logic [FW-1:0] FLast = FW'(FEATURES - 1);

  logic signed [31:0] feat_mem [MAX_SAMPLES*FEATURES];
  logic signed [31:0] tgt_mem  [MAX_SAMPLES];

  logic [15:0] lr_q;
  logic [9:0]  epochs_q, samples_q;
  lrgd_pkg::state_e st_q, st_d;

  logic [9:0]    ep_q, ep_d;
  logic [NW-1:0] s_q, s_d;
  logic [FW-1:0] f_q, f_d;
  logic [NW-1:0] n_q, n_d;
  logic [AW-1:0] a_q, a_d;
  logic signed [31:0] w_q [FEATURES];
  logic signed [63:0] g_q [FEATURES];
  logic signed [65:0] acc_q, acc_d;
  logic signed [32:0] err_q, err_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [31:0] x_q, t_q;
  logic [6:0]  dcnt_q, dcnt_d;
  logic [63:0] dquo_q, dquo_d;
  logic [NW:0] drem_q, drem_d;
  logic        dneg_q, dneg_d;
  logic [63:0] stp_q, stp_d;
  logic        ov_q, ov_d;
  logic [FW-1:0] o_q, o_d;

  logic in_fire, out_fire;
  logic [1:0] cmd;
  logic [NW:0] rem_sh;
  logic [63:0] gm;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign cmd = command_i;
  assign gm = g_q[f_q][63] ? (64'd0 - 64'(g_q[f_q])) : 64'(g_q[f_q]);
  assign rem_sh = {drem_q[NW-1:0], dquo_q[63]};

  // load writes
  always_ff @(posedge clk_i) begin
    if (in_fire && cmd == lrgd_pkg::CmdLoadFeature && 32'(sample_index_i) < MAX_SAMPLES
        && 32'(feature_index_i) < FEATURES) begin
      feat_mem[AW'(32'(sample_index_i) * FEATURES + 32'(feature_index_i))] <= value_i;
    end
    if (in_fire && cmd == lrgd_pkg::CmdLoadTarget && 32'(sample_index_i) < MAX_SAMPLES) begin
      tgt_mem[SW'(sample_index_i)] <= value_i;
    end
  end

  // synchronous reads
  always_ff @(posedge clk_i) begin
    x_q <= feat_mem[a_q];
    t_q <= tgt_mem[SW'(s_q)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q <= lrgd_pkg::ResetLr;
      epochs_q <= lrgd_pkg::ResetEpochs;
      samples_q <= lrgd_pkg::ResetSamples;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lrgd_pkg::RegLearningRate: lr_q <= cfg_data_i;
        lrgd_pkg::RegEpochCount:   epochs_q <= cfg_data_i[9:0];
        lrgd_pkg::RegSampleCount:  samples_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= lrgd_pkg::StIdle;
      ep_q <= '0; s_q <= '0; f_q <= '0; n_q <= '0; a_q <= '0;
      acc_q <= '0; err_q <= '0; prod_q <= '0;
      dcnt_q <= '0; dquo_q <= '0; drem_q <= '0; dneg_q <= 1'b0;
      stp_q <= '0; ov_q <= 1'b0; o_q <= '0;
      for (int i = 0; i < FEATURES; i++) begin
        w_q[i] <= '0;
        g_q[i] <= '0;
      end
    end else begin
      st_q <= st_d; ep_q <= ep_d; s_q <= s_d; f_q <= f_d; n_q <= n_d; a_q <= a_d;
      acc_q <= acc_d; err_q <= err_d; prod_q <= prod_d;
      dcnt_q <= dcnt_d; dquo_q <= dquo_d; drem_q <= drem_d; dneg_q <= dneg_d;
      stp_q <= stp_d; ov_q <= ov_d; o_q <= o_d;
      if (st_q == lrgd_pkg::StClear) begin
        g_q[f_q] <= '0;
        if (ep_q == '0) w_q[f_q] <= '0;
      end
      if (st_q == lrgd_pkg::StGradAcc) g_q[f_q] <= g_q[f_q] + lrgd_pkg::drop16(prod_q);
      if (st_q == lrgd_pkg::StUpdWr) begin
        w_q[f_q] <= lrgd_pkg::sat32(66'(w_q[f_q]) -
                    (dneg_q ? -$signed({2'b00, stp_q}) : $signed({2'b00, stp_q})));
      end
    end
  end

  always_comb begin
    st_d = st_q; ep_d = ep_q; s_d = s_q; f_d = f_q; n_d = n_q; a_d = a_q;
    acc_d = acc_q; err_d = err_q; prod_d = prod_q;
    dcnt_d = dcnt_q; dquo_d = dquo_q; drem_d = drem_q; dneg_d = dneg_q;
    stp_d = stp_q; ov_d = ov_q; o_d = o_q;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (st_q)
      lrgd_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i && cmd == lrgd_pkg::CmdStart) begin
          n_d = (32'(samples_q) > MAX_SAMPLES) ? NW'(MAX_SAMPLES) : NW'(samples_q);
          ep_d = '0; f_d = '0; st_d = lrgd_pkg::StClear;
        end
      end
      lrgd_pkg::StClear: begin
        if (f_q == FLast) begin
          f_d = '0;
          s_d = '0; a_d = '0; acc_d = '0;
          if (ep_q == epochs_q) begin
            o_d = '0; st_d = lrgd_pkg::StEmit;
          end else if (n_q == '0) begin
            ep_d = ep_q + 10'd1;
          end else begin
            st_d = lrgd_pkg::StPredRd;
          end
        end else f_d = f_q + 1'b1;
      end
      lrgd_pkg::StPredRd: st_d = lrgd_pkg::StPredMul;
      lrgd_pkg::StPredMul: begin
        prod_d = 64'(w_q[f_q]) * 64'(x_q);
        st_d = lrgd_pkg::StPredAcc;
      end
      lrgd_pkg::StPredAcc: begin
        acc_d = acc_q + 66'(lrgd_pkg::drop16(prod_q));
        if (f_q == FLast) begin
          f_d = '0;
          a_d = a_q - AW'(FEATURES - 1);
          st_d = lrgd_pkg::StErr;
        end else begin
          f_d = f_q + 1'b1; a_d = a_q + 1'b1; st_d = lrgd_pkg::StPredRd;
        end
      end
      lrgd_pkg::StErr: begin
        err_d = 33'(lrgd_pkg::sat32(acc_q)) - 33'(t_q);
        st_d = lrgd_pkg::StGradMul;
      end
      lrgd_pkg::StGradMul: begin
        prod_d = 64'(err_q) * 64'(x_q);
        a_d = a_q + 1'b1;
        st_d = lrgd_pkg::StGradAcc;
      end
      lrgd_pkg::StGradAcc: begin
        if (f_q == FLast) begin
          f_d = '0; acc_d = '0;
          if (s_q + 1'b1 == n_q) st_d = lrgd_pkg::StDivStart;
          else begin
            s_d = s_q + 1'b1; st_d = lrgd_pkg::StPredRd;
          end
        end else begin
          f_d = f_q + 1'b1; st_d = lrgd_pkg::StGradMul;
        end
      end
      lrgd_pkg::StDivStart: begin
        dquo_d = gm; drem_d = '0; dcnt_d = 7'd64; dneg_d = g_q[f_q][63];
        st_d = lrgd_pkg::StDivRun;
      end
      lrgd_pkg::StDivRun: begin
        if (rem_sh >= {1'b0, n_q}) begin
          drem_d = rem_sh - {1'b0, n_q};
          dquo_d = {dquo_q[62:0], 1'b1};
        end else begin
          drem_d = rem_sh;
          dquo_d = {dquo_q[62:0], 1'b0};
        end
        dcnt_d = dcnt_q - 7'd1;
        if (dcnt_q == 7'd1) st_d = lrgd_pkg::StUpdMul;
      end
      lrgd_pkg::StUpdMul: begin
        // quotient below 2^47 so the upper part fits 32 bits
        stp_d = 64'(dquo_q[47:16]) * 64'(lr_q) + ((64'(dquo_q[15:0]) * 64'(lr_q)) >> 16);
        if (dquo_q == '0) dneg_d = 1'b0;
        ov_d = 1'b0;
        st_d = lrgd_pkg::StUpdWr;
      end
      lrgd_pkg::StUpdWr: begin
        if (f_q == FLast) begin
          f_d = '0; ep_d = ep_q + 10'd1; st_d = lrgd_pkg::StClear;
        end else begin
          f_d = f_q + 1'b1; st_d = lrgd_pkg::StDivStart;
        end
      end
      lrgd_pkg::StEmit: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (o_q == FLast) st_d = lrgd_pkg::StIdle;
          else o_d = o_q + 1'b1;
        end
      end
      default: st_d = lrgd_pkg::StIdle;
    endcase
  end

  assign weight_index_o = 4'(o_q);
  assign weight_value_o = w_q[o_q];
  assign last_weight_o  = (o_q == FLast);

  `LRGD_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, in_ready_o, !out_valid_o)
  `LRGD_ASSERT_NXT(a_last_done, clk_i, rst_ni, out_fire && last_weight_o, in_ready_o)
  `LRGD_ASSERT_IMP(a_emit_range, clk_i, rst_ni, out_valid_o, 32'(o_q) < FEATURES)
  `LRGD_ASSERT_IMP(a_ov_clear, clk_i, rst_ni, in_fire, !ov_q)
endmodule
`default_nettype wire
